// File: rtl/core/gvg_pkg.sv
// Shared types, constants, microcode and sine table of the grid voltage generator.
`timescale 1ns / 1ps

package gvg_pkg;

   // Datapath geometry
   localparam int PHASE_BITS      = 32;
   localparam int SINE_INDEX_BITS = 10;
   localparam int SINE_BITS       = 16;
   localparam int SINE_QSIZE      = 2 ** (SINE_INDEX_BITS - 2);
   localparam int OUT_BITS        = 16;
   localparam int AMP_BITS        = 16;
   localparam int HAMP_BITS       = 15;
   localparam int ORDER_BITS      = 6;
   localparam int CSR_DATA_BITS   = 15;
   localparam int CSR_INDEX_BITS  = 2;
   localparam int MUL_A_BITS      = AMP_BITS + 1;
   localparam int PROD_BITS       = MUL_A_BITS + SINE_BITS;
   localparam int ACC_BITS        = PROD_BITS + 1;

   // One third of a turn, rounded
   localparam longint unsigned PHASE_THIRD_FULL = ((64'd1 << PHASE_BITS) + 64'd1) / 3;
   localparam logic [PHASE_BITS-1:0] PHASE_THIRD = PHASE_BITS'(PHASE_THIRD_FULL);

   // sqrt(2/3) in Q16
   localparam logic [15:0] AMP_SCALE_Q16 = 16'd53510;

   localparam longint unsigned HALF_PI_Q30 = 64'd1686629713;
   localparam int SINE_SH = 31 - SINE_BITS;
   localparam longint unsigned SINE_TOP = (64'd1 << (SINE_BITS - 1)) - 64'd1;

   localparam logic [CSR_DATA_BITS-1:0] SLEW_RESET = CSR_DATA_BITS'(16);

   // CSR indexes
   localparam logic [CSR_INDEX_BITS-1:0] CSR_HARMONIC_ORDER     = 2'd0;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_HARMONIC_AMPLITUDE = 2'd1;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_SLEW_STEP          = 2'd2;

   typedef struct packed {
      logic [ORDER_BITS-1:0] harmonic_order;
      logic [HAMP_BITS-1:0]  harmonic_amplitude;
      logic [CSR_DATA_BITS-1:0] slew_step;
   } cfg_type;

   // Quarter-wave sine, Q30 Taylor series through x^15, rounded to Q(SINE_BITS-1)
   function automatic longint unsigned quarter_sine(input int unsigned k);
      longint unsigned x;
      longint unsigned x2;
      longint unsigned term;
      longint unsigned q;
      longint sm;
      x    = (longint'(k) * HALF_PI_Q30) >> (SINE_INDEX_BITS - 2);
      x2   = (x * x) >> 30;
      term = x;
      sm   = longint'(x);
      term = ((term * x2) >> 30) / 6;   sm = sm - longint'(term);
      term = ((term * x2) >> 30) / 20;  sm = sm + longint'(term);
      term = ((term * x2) >> 30) / 42;  sm = sm - longint'(term);
      term = ((term * x2) >> 30) / 72;  sm = sm + longint'(term);
      term = ((term * x2) >> 30) / 110; sm = sm - longint'(term);
      term = ((term * x2) >> 30) / 156; sm = sm + longint'(term);
      term = ((term * x2) >> 30) / 210; sm = sm - longint'(term);
      if (sm < 0) begin
         sm = 0;
      end
      q = (longint'(sm) + (64'd1 << (SINE_SH - 1))) >> SINE_SH;
      if (q > SINE_TOP) begin
         q = SINE_TOP;
      end
      return q;
   endfunction

   typedef logic [SINE_BITS-2:0] sine_rom_type [SINE_QSIZE];

   function automatic sine_rom_type build_sine_rom();
      sine_rom_type rom;
      for (int k = 0; k < SINE_QSIZE; k++) begin
         rom[k] = (SINE_BITS - 1)'(quarter_sine(k));
      end
      return rom;
   endfunction

   localparam sine_rom_type SINE_ROM = build_sine_rom();
   localparam logic [SINE_BITS-2:0] SINE_PEAK = (SINE_BITS - 1)'(quarter_sine(SINE_QSIZE));

   // Angle select codes
   localparam logic [1:0] SEL_A = 2'd0;
   localparam logic [1:0] SEL_B = 2'd1;
   localparam logic [1:0] SEL_C = 2'd2;

   // Result register select
   localparam logic WR_A = 1'b0;
   localparam logic WR_B = 1'b1;

   // Sequencer conditions
   localparam logic [1:0] COND_NONE      = 2'd0;
   localparam logic [1:0] COND_WAIT_REQ  = 2'd1;
   localparam logic [1:0] COND_WAIT_OUT  = 2'd2;
   localparam logic [1:0] COND_SKIP_HARM = 2'd3;

   localparam int UCODE_LEN = 13;
   localparam int STEP_BITS = 4;

   localparam logic [STEP_BITS-1:0] STEP_IDLE   = 4'd0;
   localparam logic [STEP_BITS-1:0] STEP_WR_A   = 4'd4;
   localparam logic [STEP_BITS-1:0] STEP_WR_B   = 4'd8;
   localparam logic [STEP_BITS-1:0] STEP_COMMIT = 4'd12;

   typedef struct packed {
      logic       ld_in;
      logic       ld_theta;
      logic [1:0] theta_sel;
      logic       ld_hang;
      logic       ld_sin;
      logic       sin_hang;
      logic       mac_en;
      logic       mac_first;
      logic       mac_harm;
      logic       wr_en;
      logic       wr_sel;
      logic       commit;
   } ctrl_type;

   typedef struct packed {
      logic [1:0]           cond;
      logic [STEP_BITS-1:0] target;
      logic                 fin;
      ctrl_type             ctrl;
   } uword_type;

   typedef struct packed {
      logic out_busy;
      logic harm_off;
   } status_type;

   localparam ctrl_type C_HARM = '{ld_hang: 1'b1, ld_sin: 1'b1, default: '0};
   localparam ctrl_type C_MACF = '{mac_en: 1'b1, mac_first: 1'b1, ld_sin: 1'b1,
                                   sin_hang: 1'b1, default: '0};
   localparam ctrl_type C_MACH = '{mac_en: 1'b1, mac_harm: 1'b1, default: '0};

   localparam uword_type UCODE [UCODE_LEN] = '{
      // 0: take word, angle A
      '{cond: COND_WAIT_REQ, target: STEP_IDLE, fin: 1'b0,
        ctrl: '{ld_in: 1'b1, ld_theta: 1'b1, theta_sel: SEL_A, default: '0}},
      '{cond: COND_NONE, target: STEP_IDLE, fin: 1'b0, ctrl: C_HARM},
      '{cond: COND_SKIP_HARM, target: STEP_WR_A, fin: 1'b0, ctrl: C_MACF},
      '{cond: COND_NONE, target: STEP_IDLE, fin: 1'b0, ctrl: C_MACH},
      // 4: store A, angle B
      '{cond: COND_NONE, target: STEP_IDLE, fin: 1'b0,
        ctrl: '{ld_theta: 1'b1, theta_sel: SEL_B, wr_en: 1'b1, wr_sel: WR_A,
                default: '0}},
      '{cond: COND_NONE, target: STEP_IDLE, fin: 1'b0, ctrl: C_HARM},
      '{cond: COND_SKIP_HARM, target: STEP_WR_B, fin: 1'b0, ctrl: C_MACF},
      '{cond: COND_NONE, target: STEP_IDLE, fin: 1'b0, ctrl: C_MACH},
      // 8: store B, angle C
      '{cond: COND_NONE, target: STEP_IDLE, fin: 1'b0,
        ctrl: '{ld_theta: 1'b1, theta_sel: SEL_C, wr_en: 1'b1, wr_sel: WR_B,
                default: '0}},
      '{cond: COND_NONE, target: STEP_IDLE, fin: 1'b0, ctrl: C_HARM},
      '{cond: COND_SKIP_HARM, target: STEP_COMMIT, fin: 1'b0, ctrl: C_MACF},
      '{cond: COND_NONE, target: STEP_IDLE, fin: 1'b0, ctrl: C_MACH},
      // 12: wait for output register, publish, update state
      '{cond: COND_WAIT_OUT, target: STEP_IDLE, fin: 1'b1,
        ctrl: '{commit: 1'b1, default: '0}}
   };

endpackage

// File: rtl/core/three_phase_grid_voltage_generator_unit.sv
// Three-phase grid voltage generator: CSRs, microcode sequencer and datapath.
`timescale 1ns / 1ps
// A word is taken at step 0, and its result is published through the output register
//   when step 12 commits; when the active harmonic amplitude is zero, the harmonic
//   multiply step of each phase is skipped. A new word is taken only back at step 0;
//   the shared multiplier and sine table take the six sine terms in turn under the microcode.
// Reset (synchronous): phase, amplitude and harmonic amplitude clear, slew step is 16.

module three_phase_grid_voltage_generator_unit import gvg_pkg::*; (
   input  logic                       clock,
   input  logic                       reset,
   // input words
   input  logic                       req_valid,
   output logic                       req_stall,
   input  logic [15:0]                req_line_voltage_target,
   input  logic [31:0]                req_phase_step,
   // result words
   output logic                       rsp_valid,
   input  logic                       rsp_stall,
   output logic signed [OUT_BITS-1:0] rsp_phase_a_voltage,
   output logic signed [OUT_BITS-1:0] rsp_phase_b_voltage,
   output logic signed [OUT_BITS-1:0] rsp_phase_c_voltage,
   output logic                       rsp_clipped,
   // configuration
   input  logic                       csr_write_enable,
   input  logic [CSR_INDEX_BITS-1:0]  csr_index,
   input  logic [CSR_DATA_BITS-1:0]   csr_write_data
);

   cfg_type    cfg_ff;
   ctrl_type   ctrl;
   status_type status;

   // CSR bank; an index past the last register is dropped
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.harmonic_order     <= '0;
         cfg_ff.harmonic_amplitude <= '0;
         cfg_ff.slew_step          <= SLEW_RESET;
      end else if (csr_write_enable) begin
         unique case (csr_index)
            CSR_HARMONIC_ORDER:     cfg_ff.harmonic_order     <= csr_write_data[ORDER_BITS-1:0];
            CSR_HARMONIC_AMPLITUDE: cfg_ff.harmonic_amplitude <= csr_write_data[HAMP_BITS-1:0];
            CSR_SLEW_STEP:          cfg_ff.slew_step          <= csr_write_data;
            default: ;
         endcase
      end
   end

   // Step 0 waits for a word; steps 1..11 form three phase sums; step 12 waits for the
   // output register to free up, then publishes and advances the tick state.
   gvg_sequencer u_seq (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .status    (status),
      .req_stall (req_stall),
      .ctrl      (ctrl)
   );

   gvg_datapath u_dp (
      .clock                   (clock),
      .reset                   (reset),
      .ctrl                    (ctrl),
      .cfg                     (cfg_ff),
      .req_line_voltage_target (req_line_voltage_target),
      .req_phase_step          (req_phase_step),
      .rsp_stall               (rsp_stall),
      .rsp_valid               (rsp_valid),
      .rsp_phase_a_voltage     (rsp_phase_a_voltage),
      .rsp_phase_b_voltage     (rsp_phase_b_voltage),
      .rsp_phase_c_voltage     (rsp_phase_c_voltage),
      .rsp_clipped             (rsp_clipped),
      .status                  (status)
   );

endmodule

// File: rtl/core/gvg_sine_rom.sv
// Full-wave sine lookup from the quarter-wave table.
`timescale 1ns / 1ps

module gvg_sine_rom import gvg_pkg::*; (
   input  logic [PHASE_BITS-1:0]       angle,
   output logic signed [SINE_BITS-1:0] value
);

   logic [SINE_INDEX_BITS-1:0] idx;
   logic [1:0]                 quad;
   logic [SINE_INDEX_BITS-3:0] k;
   logic [SINE_INDEX_BITS-3:0] k_mirror;
   logic [SINE_BITS-2:0]       mag;
   logic signed [SINE_BITS-1:0] mag_s;

   assign idx      = angle[PHASE_BITS-1 -: SINE_INDEX_BITS];
   assign quad     = idx[SINE_INDEX_BITS-1 -: 2];
   assign k        = idx[SINE_INDEX_BITS-3:0];
   assign k_mirror = '0 - k;

   always_comb begin
      if (!quad[0]) begin
         mag = SINE_ROM[k];
      end else if (k == '0) begin
         mag = SINE_PEAK;   // exactly a quarter or three-quarter turn
      end else begin
         mag = SINE_ROM[k_mirror];
      end
   end

   assign mag_s = $signed({1'b0, mag});
   assign value = quad[1] ? -mag_s : mag_s;

endmodule

// File: rtl/core/gvg_sequencer.sv
// Microcode step counter with wait and skip conditions.
`timescale 1ns / 1ps

module gvg_sequencer import gvg_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   input  status_type status,
   output logic       req_stall,
   output ctrl_type   ctrl
);

   logic [STEP_BITS-1:0] step_ff;
   logic [STEP_BITS-1:0] step_in;
   uword_type            word;
   logic                 hold;
   logic                 jump;

   assign word = UCODE[step_ff];
   assign hold = ((word.cond == COND_WAIT_REQ) && !req_valid) ||
                 ((word.cond == COND_WAIT_OUT) && status.out_busy);
   assign jump = (word.cond == COND_SKIP_HARM) && status.harm_off;

   always_comb begin
      priority if (hold) begin
         step_in = step_ff;
      end else if (jump) begin
         step_in = word.target;
      end else if (word.fin) begin
         step_in = STEP_IDLE;
      end else begin
         step_in = step_ff + STEP_BITS'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         step_ff <= STEP_IDLE;
      end else begin
         step_ff <= step_in;
      end
   end

   assign ctrl      = hold ? '0 : word.ctrl;
   assign req_stall = (step_ff != STEP_IDLE);

endmodule

// File: rtl/core/gvg_datapath.sv
// Angle, sine, multiply-accumulate, saturation and tick state registers.
`timescale 1ns / 1ps

module gvg_datapath import gvg_pkg::*; (
   input  logic                        clock,
   input  logic                        reset,
   input  ctrl_type                    ctrl,
   input  cfg_type                     cfg,
   input  logic [15:0]                 req_line_voltage_target,
   input  logic [31:0]                 req_phase_step,
   input  logic                        rsp_stall,
   output logic                        rsp_valid,
   output logic signed [OUT_BITS-1:0]  rsp_phase_a_voltage,
   output logic signed [OUT_BITS-1:0]  rsp_phase_b_voltage,
   output logic signed [OUT_BITS-1:0]  rsp_phase_c_voltage,
   output logic                        rsp_clipped,
   output status_type                  status
);

   localparam int RND_BITS = ACC_BITS + 1;
   localparam int SHR_BITS = RND_BITS - (SINE_BITS - 1);
   localparam logic signed [RND_BITS-1:0] RND_HALF = RND_BITS'(2 ** (SINE_BITS - 2));
   localparam logic signed [SHR_BITS-1:0] VMAX = SHR_BITS'(2 ** (OUT_BITS - 1) - 1);
   localparam logic signed [SHR_BITS-1:0] VMIN = SHR_BITS'(-(2 ** (OUT_BITS - 1)));

   // tick state
   logic [PHASE_BITS-1:0] phase_ff, phase_in;
   logic [AMP_BITS-1:0]   amp_ff, amp_in;
   logic [HAMP_BITS-1:0]  hamp_ff;

   // working registers
   logic [PHASE_BITS-1:0]       step_ff;
   logic [AMP_BITS-1:0]         target_ff, target_in;
   logic [PHASE_BITS-1:0]       theta_ff, theta_in;
   logic [PHASE_BITS-1:0]       hang_ff;
   logic signed [SINE_BITS-1:0] sin_ff;
   logic signed [ACC_BITS-1:0]  acc_ff, acc_in;
   logic signed [OUT_BITS-1:0]  res_a_ff, res_b_ff;
   logic                        clip_ff;

   // output register
   logic                        rsp_valid_ff;
   logic signed [OUT_BITS-1:0]  rsp_a_ff, rsp_b_ff, rsp_c_ff;
   logic                        rsp_clip_ff;

   logic [2*AMP_BITS:0]               tgt_full;
   logic [PHASE_BITS+ORDER_BITS-1:0]  hprod;
   logic signed [SINE_BITS-1:0]       sine_val;
   logic signed [MUL_A_BITS-1:0]      mul_a;
   logic signed [PROD_BITS-1:0]       prod;
   logic signed [RND_BITS-1:0]        rnd;
   logic signed [SHR_BITS-1:0]        shr;
   logic                              sat;
   logic signed [OUT_BITS-1:0]        volt;
   logic [AMP_BITS-1:0]               slew;
   logic [AMP_BITS-1:0]               diff;

   // amplitude target, sqrt(2/3) rounded half up
   assign tgt_full  = (2 * AMP_BITS + 1)'(req_line_voltage_target) *
                      (2 * AMP_BITS + 1)'(AMP_SCALE_Q16) +
                      (2 * AMP_BITS + 1)'(2 ** (AMP_BITS - 1));
   assign target_in = tgt_full[2*AMP_BITS-1:AMP_BITS];

   always_comb begin
      unique case (ctrl.theta_sel)
         SEL_A:   theta_in = phase_ff;
         SEL_B:   theta_in = phase_ff - PHASE_THIRD;
         SEL_C:   theta_in = phase_ff + PHASE_THIRD;
         default: theta_in = phase_ff;
      endcase
   end

   assign hprod = (PHASE_BITS + ORDER_BITS)'(theta_ff) *
                  (PHASE_BITS + ORDER_BITS)'(cfg.harmonic_order);

   gvg_sine_rom u_sine (
      .angle (ctrl.sin_hang ? hang_ff : theta_ff),
      .value (sine_val)
   );

   assign mul_a  = ctrl.mac_harm ? $signed(MUL_A_BITS'(hamp_ff)) : $signed(MUL_A_BITS'(amp_ff));
   assign prod   = mul_a * sin_ff;
   assign acc_in = ctrl.mac_first ? ACC_BITS'(prod) : acc_ff + ACC_BITS'(prod);

   // round half up, then saturate
   assign rnd  = RND_BITS'(acc_ff) + RND_HALF;
   assign shr  = $signed(rnd[RND_BITS-1:SINE_BITS-1]);
   assign sat  = (shr > VMAX) || (shr < VMIN);
   always_comb begin
      priority if (shr > VMAX) begin
         volt = VMAX[OUT_BITS-1:0];
      end else if (shr < VMIN) begin
         volt = VMIN[OUT_BITS-1:0];
      end else begin
         volt = shr[OUT_BITS-1:0];
      end
   end

   // slew limiter
   assign slew = AMP_BITS'(cfg.slew_step);
   always_comb begin
      if (target_ff > amp_ff) begin
         diff   = target_ff - amp_ff;
         amp_in = (diff > slew) ? amp_ff + slew : target_ff;
      end else begin
         diff   = amp_ff - target_ff;
         amp_in = (diff > slew) ? amp_ff - slew : target_ff;
      end
   end

   assign phase_in = phase_ff + step_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff     <= '0;
         amp_ff       <= '0;
         hamp_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (ctrl.commit) begin
            phase_ff     <= phase_in;
            amp_ff       <= amp_in;
            hamp_ff      <= (cfg.harmonic_order == '0) ? '0 : cfg.harmonic_amplitude;
            rsp_valid_ff <= 1'b1;
         end else if (rsp_valid_ff && !rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (ctrl.ld_in) begin
         step_ff   <= req_phase_step;
         target_ff <= target_in;
      end
      if (ctrl.ld_theta) begin
         theta_ff <= theta_in;
      end
      if (ctrl.ld_hang) begin
         hang_ff <= hprod[PHASE_BITS-1:0];
      end
      if (ctrl.ld_sin) begin
         sin_ff <= sine_val;
      end
      if (ctrl.mac_en) begin
         acc_ff <= acc_in;
      end
      if (ctrl.ld_in) begin
         clip_ff <= 1'b0;
      end else if (ctrl.wr_en) begin
         clip_ff <= clip_ff | sat;
      end
      if (ctrl.wr_en && ctrl.wr_sel == WR_A) begin
         res_a_ff <= volt;
      end
      if (ctrl.wr_en && ctrl.wr_sel == WR_B) begin
         res_b_ff <= volt;
      end
      if (ctrl.commit) begin
         rsp_a_ff    <= res_a_ff;
         rsp_b_ff    <= res_b_ff;
         rsp_c_ff    <= volt;
         rsp_clip_ff <= clip_ff | sat;
      end
   end

   assign rsp_valid           = rsp_valid_ff;
   assign rsp_phase_a_voltage = rsp_a_ff;
   assign rsp_phase_b_voltage = rsp_b_ff;
   assign rsp_phase_c_voltage = rsp_c_ff;
   assign rsp_clipped         = rsp_clip_ff;

   assign status.out_busy = rsp_valid_ff && rsp_stall;
   assign status.harm_off = (hamp_ff == '0);

endmodule

// File: rtl/core/gvg_checker.sv
// Port-level checks for the grid voltage generator, bound to the top level.
`timescale 1ns / 1ps

module gvg_checker import gvg_pkg::*; (
   input logic                       clock,
   input logic                       reset,
   input logic                       req_valid,
   input logic                       req_stall,
   input logic                       rsp_valid,
   input logic                       rsp_stall,
   input logic signed [OUT_BITS-1:0] rsp_phase_a_voltage,
   input logic signed [OUT_BITS-1:0] rsp_phase_b_voltage,
   input logic signed [OUT_BITS-1:0] rsp_phase_c_voltage,
   input logic                       rsp_clipped
);

   localparam logic signed [OUT_BITS-1:0] RAIL_HI = OUT_BITS'(2 ** (OUT_BITS - 1) - 1);
   localparam logic signed [OUT_BITS-1:0] RAIL_LO = OUT_BITS'(-(2 ** (OUT_BITS - 1)));

   // busy after taking a word
   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall) |=> req_stall)
      else $error("input taken on back-to-back cycles");

   // a result never appears the cycle after a word is taken
   a_no_instant_result: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall) |=> !$rose(rsp_valid))
      else $error("result published too early");

   // clip flag only with a phase on a rail
   a_clip_on_rail: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_clipped) |->
         (rsp_phase_a_voltage == RAIL_HI || rsp_phase_a_voltage == RAIL_LO ||
          rsp_phase_b_voltage == RAIL_HI || rsp_phase_b_voltage == RAIL_LO ||
          rsp_phase_c_voltage == RAIL_HI || rsp_phase_c_voltage == RAIL_LO))
      else $error("clipped without saturated phase");

   // stalled result word holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_stall) |=>
         (rsp_valid && $stable(rsp_phase_a_voltage) && $stable(rsp_phase_b_voltage) &&
          $stable(rsp_phase_c_voltage) && $stable(rsp_clipped)))
      else $error("stalled result changed");

endmodule

bind three_phase_grid_voltage_generator_unit gvg_checker u_gvg_checker (.*);
